FILE: rtl/tdcwp_pkg.sv
// Package: word type codes, sequencer states and adder unit types for the TDC word parser.
package tdcwp_pkg;

    localparam int WORD_W    = 32;
    localparam int TS_W      = 49;
    localparam int CHAN_W    = 5;
    localparam int VALUE_W   = 21;
    localparam int TIME_W    = 64;
    localparam int HIT_W     = CHAN_W + VALUE_W;

    localparam logic [4:0] TYPE_MEASURE  = 5'h00;
    localparam logic [4:0] TYPE_TRAILER  = 5'h10;
    localparam logic [4:0] TYPE_EXT_TIME = 5'h11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_WRAP,
        ST_LO,
        ST_HI,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
        logic        cin;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        cout;
    } alu_res_t;

endpackage

FILE: rtl/tdcwp_if.sv
// Valid/ready channel interfaces for readout words and decoded hits.
interface tdcwp_word_if;
    import tdcwp_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   word;
    logic [TS_W-1:0]     adc_timestamp;
    logic                bank_end;

    modport source (output valid, output word, output adc_timestamp, output bank_end,
                    input ready);
    modport sink   (input valid, input word, input adc_timestamp, input bank_end,
                    output ready);
endinterface

interface tdcwp_hit_if;
    import tdcwp_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   hit_channel;
    logic [VALUE_W-1:0]  hit_value;
    logic [TS_W-1:0]     event_timestamp;
    logic [TIME_W-1:0]   tdc_time;
    logic                hits_dropped;
    logic                last_hit;

    modport source (output valid, output hit_channel, output hit_value,
                    output event_timestamp, output tdc_time, output hits_dropped,
                    output last_hit, input ready);
    modport sink   (input valid, input hit_channel, input hit_value,
                    input event_timestamp, input tdc_time, input hits_dropped,
                    input last_hit, output ready);
endinterface

FILE: rtl/tdcwp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdcwp_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/tdcwp_alu.sv
// Shared 32-bit add/subtract unit with carry in and carry out.
module tdcwp_alu (
    input  tdcwp_pkg::alu_req_t req,
    output tdcwp_pkg::alu_res_t res
);
    import tdcwp_pkg::*;

    logic [31:0] b_eff;
    logic [32:0] total;

    always_comb
    begin
        case (req.op)
            ALU_ADD: b_eff = req.b;
            ALU_SUB: b_eff = ~req.b;
            default: b_eff = req.b;
        endcase
        total    = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, req.cin};
        res.sum  = total[31:0];
        res.cout = total[32];
    end
endmodule

FILE: rtl/tdc_event_word_parser.sv
// Top level: TDC readout word parser with hit buffer and extended trigger time.
//
//  channel | direction | transaction
//  --------+-----------+------------------------------------------------------
//  words   | in        | word, adc_timestamp, bank_end
//  hits    | out       | hit_channel, hit_value, event_timestamp, tdc_time,
//          |           | hits_dropped, last_hit
//
// Measurement, time and ignored words are accepted while idle.
// A global trailer then runs on the shared 32-bit adder through wrap compare, wrap increment,
// and the low and high halves of extended time*5, then drains each buffered hit by a buffer
// RAM read and an output register load; words is not ready meanwhile.
// Output stalls hold the drain; a finished hit waits in the output register.
// Reset clears the hit count, overflow flag and time tracking at once; the buffer RAM is not cleared.
module tdc_event_word_parser #(
    parameter int MAX_HITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    tdcwp_word_if.sink       words,
    tdcwp_hit_if.source      hits
);
    import tdcwp_pkg::*;

    localparam int CNT_W = $clog2(MAX_HITS + 1);
    localparam int IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [31:0]         partial_reg, partial_next;
    logic [31:0]         prev_reg, prev_next;
    logic [31:0]         wrap_reg, wrap_next;
    logic [31:0]         trig_reg, trig_next;
    logic [TS_W-1:0]     ts_reg, ts_next;
    logic [CNT_W-1:0]    drain_cnt_reg, drain_cnt_next;
    logic                drain_ovf_reg, drain_ovf_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                lt_reg, lt_next;
    logic                carry_reg, carry_next;
    logic [31:0]         lo_reg, lo_next;
    logic [31:0]         hi_reg, hi_next;

    logic                out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]   out_chan_reg, out_chan_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [TS_W-1:0]     out_ts_reg, out_ts_next;
    logic [TIME_W-1:0]   out_time_reg, out_time_next;
    logic                out_drop_reg, out_drop_next;
    logic                out_last_reg, out_last_next;

    logic [CNT_W-1:0]    idx_inc;
    logic                idx_last;
    logic [4:0]          word_type;
    logic                ram_we;
    logic                ram_re;
    logic [HIT_W-1:0]    ram_rdata;
    alu_req_t            alu_req;
    alu_res_t            alu_res;

    tdcwp_ram #(
        .WIDTH (HIT_W),
        .DEPTH (MAX_HITS),
        .AW    (IDX_W)
    ) u_hit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (words.word[HIT_W-1:0]),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    tdcwp_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign words.ready           = (state_reg == ST_IDLE);
    assign hits.valid            = out_valid_reg;
    assign hits.hit_channel      = out_chan_reg;
    assign hits.hit_value        = out_value_reg;
    assign hits.event_timestamp  = out_ts_reg;
    assign hits.tdc_time         = out_time_reg;
    assign hits.hits_dropped     = out_drop_reg;
    assign hits.last_hit         = out_last_reg;

    assign word_type = words.word[31:27];
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_last  = (idx_inc == drain_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            partial_reg   <= '0;
            prev_reg      <= '0;
            wrap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            partial_reg   <= partial_next;
            prev_reg      <= prev_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg      <= trig_next;
        ts_reg        <= ts_next;
        drain_cnt_reg <= drain_cnt_next;
        drain_ovf_reg <= drain_ovf_next;
        idx_reg       <= idx_next;
        lt_reg        <= lt_next;
        carry_reg     <= carry_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        out_chan_reg  <= out_chan_next;
        out_value_reg <= out_value_next;
        out_ts_reg    <= out_ts_next;
        out_time_reg  <= out_time_next;
        out_drop_reg  <= out_drop_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        partial_next   = partial_reg;
        prev_next      = prev_reg;
        wrap_next      = wrap_reg;
        trig_next      = trig_reg;
        ts_next        = ts_reg;
        drain_cnt_next = drain_cnt_reg;
        drain_ovf_next = drain_ovf_reg;
        idx_next       = idx_reg;
        lt_next        = lt_reg;
        carry_next     = carry_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !hits.ready;
        out_chan_next  = out_chan_reg;
        out_value_next = out_value_reg;
        out_ts_next    = out_ts_reg;
        out_time_next  = out_time_reg;
        out_drop_next  = out_drop_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        alu_req.op     = ALU_ADD;
        alu_req.a      = '0;
        alu_req.b      = '0;
        alu_req.cin    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (words.valid)
                begin
                    case (word_type)
                        TYPE_MEASURE:
                        begin
                            if (count_reg < CNT_W'(MAX_HITS))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        TYPE_EXT_TIME:
                        begin
                            partial_next = {words.word[26:0], 5'd0};
                        end
                        TYPE_TRAILER:
                        begin
                            trig_next      = partial_reg | {27'd0, words.word[4:0]};
                            ts_next        = words.adc_timestamp;
                            drain_cnt_next = count_reg;
                            drain_ovf_next = ovf_reg;
                            idx_next       = '0;
                            count_next     = '0;
                            ovf_next       = 1'b0;
                            partial_next   = '0;
                            state_next     = ST_CMP;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (words.bank_end)
                    begin
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        partial_next = '0;
                    end
                end
            end
            ST_CMP:
            begin
                // borrow out of time - prev means time fell
                alu_req.op  = ALU_SUB;
                alu_req.a   = trig_reg;
                alu_req.b   = prev_reg;
                alu_req.cin = 1'b1;
                lt_next     = !alu_res.cout;
                prev_next   = trig_reg;
                state_next  = ST_WRAP;
            end
            ST_WRAP:
            begin
                alu_req.a   = wrap_reg;
                alu_req.cin = lt_reg;
                wrap_next   = alu_res.sum;
                state_next  = ST_LO;
            end
            ST_LO:
            begin
                // ext*5 = ext*4 + ext, ext = {wrap, time}
                alu_req.a  = {trig_reg[29:0], 2'b00};
                alu_req.b  = trig_reg;
                lo_next    = alu_res.sum;
                carry_next = alu_res.cout;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                alu_req.a   = {wrap_reg[29:0], trig_reg[31:30]};
                alu_req.b   = wrap_reg;
                alu_req.cin = carry_reg;
                hi_next     = alu_res.sum;
                state_next  = (drain_cnt_reg == '0) ? ST_IDLE : ST_READ;
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || hits.ready)
                begin
                    out_valid_next = 1'b1;
                    out_chan_next  = ram_rdata[HIT_W-1:VALUE_W];
                    out_value_next = ram_rdata[VALUE_W-1:0];
                    out_ts_next    = ts_reg;
                    out_time_next  = {1'b0, hi_reg, lo_reg[31:1]};
                    out_drop_next  = drain_ovf_reg;
                    out_last_next  = idx_last;
                    idx_next       = idx_inc;
                    state_next     = idx_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
